// File: rtl/core/fcs_pkg.sv
// Shared types and constants of the fractional circular shift block.
`timescale 1ns / 1ps

package fcs_pkg;

	localparam int IDX_W      = 12;
	localparam int SAMPLE_W   = 32;
	localparam int FRAC_W     = 8;
	localparam int SHIFT_W    = 21;
	localparam int LEN_W      = 13;
	localparam int OUT_W      = SAMPLE_W + FRAC_W;
	localparam int IN_DATA_W  = ((IDX_W + SAMPLE_W + 7) / 8) * 8;
	localparam int OUT_DATA_W = ((OUT_W + 7) / 8) * 8;
	localparam int REG_IDX_W  = 1;
	localparam int QDEPTH     = 4;
	localparam int ODEPTH     = 4;

	localparam int MAX_LENGTH_DEF = 4096;

	// register indexes of the configuration port
	localparam logic [REG_IDX_W-1:0] REG_SHIFT  = 1'b0;
	localparam logic [REG_IDX_W-1:0] REG_LENGTH = 1'b1;

	// input kinds carried in tuser
	localparam logic MODE_WRITE = 1'b0;
	localparam logic MODE_READ  = 1'b1;

	typedef enum logic [1:0] {
		OP_WRITE = 2'd0,
		OP_READ  = 2'd1,
		OP_OOR   = 2'd2
	} op_t;

	// reduced offsets and length, as seen by the front
	typedef struct packed {
		logic [LEN_W-1:0] curve_len;
		logic [LEN_W-1:0] floor_off;
		logic [LEN_W-1:0] ceil_off;
	} offs_t;

	// classified request handed from front to back
	typedef struct packed {
		op_t                        op;
		logic [LEN_W-1:0]           addr_a;
		logic [LEN_W-1:0]           addr_b;
		logic signed [SAMPLE_W-1:0] sample;
	} req_t;

	typedef struct packed {
		logic                    oor;
		logic signed [OUT_W-1:0] value;
	} res_t;

endpackage

// File: rtl/core/fcs_fifo.sv
// Small register FIFO used for the request queue and the result buffer.
`timescale 1ns / 1ps

module fcs_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       push,
	input  logic [WIDTH-1:0]           push_data,
	input  logic                       pop,
	output logic [WIDTH-1:0]           pop_data,
	output logic                       valid,
	output logic                       full,
	output logic [$clog2(DEPTH):0]     count
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH) + 1;

	logic [WIDTH-1:0] slot_q [DEPTH];
	logic [PW-1:0]    wr_ptr_q;
	logic [PW-1:0]    rd_ptr_q;
	logic [CW-1:0]    count_q;
	logic             do_push;
	logic             do_pop;

	assign valid    = (count_q != '0);
	assign full     = (count_q == CW'(DEPTH));
	assign count    = count_q;
	assign pop_data = slot_q[rd_ptr_q];
	assign do_push  = push && !full;
	assign do_pop   = pop && valid;

	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			count_q <= count_q + CW'(do_push) - CW'(do_pop);
		end
	end

endmodule

// File: rtl/core/fcs_offset.sv
// Configuration registers and the bit-serial reduction of the shift offsets.
`timescale 1ns / 1ps

module fcs_offset import fcs_pkg::*; #(
	parameter int MAX_LENGTH = MAX_LENGTH_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_wen,
	input  logic [REG_IDX_W-1:0] cfg_index,
	input  logic [SHIFT_W-1:0]   cfg_wdata,
	output logic [FRAC_W-1:0]    frac,
	output offs_t                offs,
	output logic                 busy
);

	localparam int LEN_TOP = (1 << LEN_W) - 1;
	localparam logic [LEN_W-1:0] LEN_CAP =
		LEN_W'((MAX_LENGTH > LEN_TOP) ? LEN_TOP : MAX_LENGTH);
	localparam int CNT_W = $clog2(LEN_W);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_LOAD,
		ST_DIV,
		ST_FIX
	} state_t;

	state_t                   state_q;
	logic [SHIFT_W-1:0]       shift_q;
	logic [LEN_W-1:0]         len_q;
	logic [LEN_W-1:0]         floor_q;
	logic [LEN_W-1:0]         ceil_q;
	logic [LEN_W-1:0]         dvd_q;
	logic [LEN_W-1:0]         rem_q;
	logic [CNT_W-1:0]         cnt_q;
	logic                     neg_q;

	logic signed [LEN_W-1:0]  whole;
	logic [LEN_W-1:0]         new_len;
	logic [LEN_W:0]           trial;
	logic [LEN_W-1:0]         red;
	logic [LEN_W-1:0]         red_inc;

	always_comb begin
		// integer part of the shift, rounded towards minus infinity
		whole = $signed(shift_q[SHIFT_W-1:FRAC_W]);

		new_len = cfg_wdata[LEN_W-1:0];
		if (new_len == '0) begin
			new_len = LEN_W'(1);
		end else if (new_len > LEN_CAP) begin
			new_len = LEN_CAP;
		end

		trial = {rem_q, dvd_q[LEN_W-1]};

		// remainder of the magnitude, folded back for a negative shift
		red = (neg_q && rem_q != '0) ? len_q - rem_q : rem_q;
		red_inc = red + 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			shift_q <= '0;
			len_q   <= LEN_CAP;
			floor_q <= '0;
			ceil_q  <= '0;
			dvd_q   <= '0;
			rem_q   <= '0;
			cnt_q   <= '0;
			neg_q   <= 1'b0;
		end else if (cfg_wen) begin
			// a register write restarts the reduction
			unique case (cfg_index)
				REG_SHIFT: begin
					shift_q <= cfg_wdata;
					state_q <= ST_LOAD;
				end
				REG_LENGTH: begin
					len_q   <= new_len;
					state_q <= ST_LOAD;
				end
				default: begin
				end
			endcase
		end else begin
			unique case (state_q)
				ST_IDLE: begin
				end
				ST_LOAD: begin
					neg_q   <= whole[LEN_W-1];
					dvd_q   <= whole[LEN_W-1] ? LEN_W'(-whole) : LEN_W'(whole);
					rem_q   <= '0;
					cnt_q   <= '0;
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					if (trial >= {1'b0, len_q}) begin
						rem_q <= LEN_W'(trial - {1'b0, len_q});
					end else begin
						rem_q <= LEN_W'(trial);
					end
					dvd_q <= dvd_q << 1;
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == CNT_W'(LEN_W - 1)) begin
						state_q <= ST_FIX;
					end
				end
				ST_FIX: begin
					floor_q <= red;
					if (shift_q[FRAC_W-1:0] == '0) begin
						ceil_q <= red;
					end else if (red_inc == len_q) begin
						ceil_q <= '0;
					end else begin
						ceil_q <= red_inc;
					end
					state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign frac           = shift_q[FRAC_W-1:0];
	assign offs.curve_len = len_q;
	assign offs.floor_off = floor_q;
	assign offs.ceil_off  = ceil_q;
	assign busy           = (state_q != ST_IDLE);

endmodule

// File: rtl/core/fcs_front.sv
// Front end: accept input requests, classify them and form the two read addresses.
`timescale 1ns / 1ps

module fcs_front import fcs_pkg::*; #(
	parameter int MAX_LENGTH = MAX_LENGTH_DEF
) (
	input  logic                 s_axis_tvalid,
	output logic                 s_axis_tready,
	input  logic [IN_DATA_W-1:0] s_axis_tdata,
	input  logic                 s_axis_tuser,
	input  offs_t                offs,
	input  logic                 busy,
	input  logic                 q_full,
	output logic                 q_push,
	output req_t                 q_data
);

	logic [IDX_W-1:0] idx;
	logic [LEN_W:0]   len_x;
	logic [LEN_W:0]   sum_a;
	logic [LEN_W:0]   sum_b;
	logic [LEN_W:0]   wrap_a;
	logic [LEN_W:0]   wrap_b;
	logic             keep;

	always_comb begin
		idx   = s_axis_tdata[IDX_W-1:0];
		len_x = {1'b0, offs.curve_len};
		sum_a = (LEN_W + 1)'(idx) + {1'b0, offs.floor_off};
		sum_b = (LEN_W + 1)'(idx) + {1'b0, offs.ceil_off};
		wrap_a = (sum_a >= len_x) ? sum_a - len_x : sum_a;
		wrap_b = (sum_b >= len_x) ? sum_b - len_x : sum_b;

		q_data.sample = $signed(s_axis_tdata[IDX_W+SAMPLE_W-1:IDX_W]);
		keep = 1'b1;
		unique case (s_axis_tuser)
			MODE_WRITE: begin
				q_data.op     = OP_WRITE;
				q_data.addr_a = LEN_W'(idx);
				q_data.addr_b = LEN_W'(idx);
				keep          = (32'(idx) < MAX_LENGTH);
			end
			MODE_READ: begin
				q_data.op     = ((LEN_W + 1)'(idx) >= len_x) ? OP_OOR : OP_READ;
				q_data.addr_a = LEN_W'(wrap_a);
				q_data.addr_b = LEN_W'(wrap_b);
			end
			default: begin
				q_data.op     = OP_OOR;
				q_data.addr_a = '0;
				q_data.addr_b = '0;
			end
		endcase
	end

	assign s_axis_tready = !busy && !q_full;
	assign q_push        = s_axis_tvalid && s_axis_tready && keep;

endmodule

// File: rtl/core/fcs_back.sv
// Back end: sample store, two-tap blend pipeline and result buffer.
`timescale 1ns / 1ps

module fcs_back import fcs_pkg::*; #(
	parameter int MAX_LENGTH = MAX_LENGTH_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic [FRAC_W-1:0]     frac,
	input  logic                  q_valid,
	input  req_t                  q_data,
	output logic                  q_pop,
	output logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	output logic [OUT_DATA_W-1:0] m_axis_tdata,
	output logic                  m_axis_tuser
);

	localparam int AW   = (MAX_LENGTH > 1) ? $clog2(MAX_LENGTH) : 1;
	localparam int CW   = $clog2(ODEPTH) + 1;
	localparam int PROD = SAMPLE_W + FRAC_W + 2;

	logic signed [SAMPLE_W-1:0] mem [MAX_LENGTH];

	logic                       v_s1;
	logic                       oor_s1;
	logic signed [SAMPLE_W-1:0] a_s1;
	logic signed [SAMPLE_W-1:0] b_s1;
	logic                       v_s2;
	logic                       oor_s2;
	logic signed [PROD-1:0]     pa_s2;
	logic signed [PROD-1:0]     pb_s2;

	logic [FRAC_W:0]            wa;
	logic [FRAC_W:0]            wb;
	logic [CW:0]                pending;
	logic                       is_result;
	logic [CW-1:0]              ocount;
	logic                       ofull;
	res_t                       res;
	res_t                       head;

	assign wa = (FRAC_W + 1)'(1 << FRAC_W) - {1'b0, frac};
	assign wb = {1'b0, frac};

	// results already owed plus those in flight must fit the buffer
	assign pending = {1'b0, ocount} + (CW + 1)'(v_s1) + (CW + 1)'(v_s2);
	assign q_pop   = q_valid && (pending < (CW + 1)'(ODEPTH));

	always_comb begin
		case (q_data.op) inside
			OP_READ, OP_OOR: is_result = 1'b1;
			default:         is_result = 1'b0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (q_pop && q_data.op == OP_WRITE) begin
			mem[AW'(q_data.addr_a)] <= q_data.sample;
		end
		if (q_pop) begin
			a_s1 <= mem[AW'(q_data.addr_a)];
			b_s1 <= mem[AW'(q_data.addr_b)];
		end
	end

	always_ff @(posedge clk) begin
		pa_s2 <= $signed(a_s1) * $signed({1'b0, wa});
		pb_s2 <= $signed(b_s1) * $signed({1'b0, wb});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1   <= 1'b0;
			oor_s1 <= 1'b0;
			v_s2   <= 1'b0;
			oor_s2 <= 1'b0;
		end else begin
			v_s1   <= q_pop && is_result;
			oor_s1 <= (q_data.op == OP_OOR);
			v_s2   <= v_s1;
			oor_s2 <= oor_s1;
		end
	end

	assign res.oor   = oor_s2;
	assign res.value = oor_s2 ? '0 : OUT_W'(pa_s2 + pb_s2);

	fcs_fifo #(
		.WIDTH ($bits(res_t)),
		.DEPTH (ODEPTH)
	) u_out_buf (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (v_s2),
		.push_data (res),
		.pop       (m_axis_tready),
		.pop_data  (head),
		.valid     (m_axis_tvalid),
		.full      (ofull),
		.count     (ocount)
	);

	assign m_axis_tdata = OUT_DATA_W'(head.value) | OUT_DATA_W'({ofull & 1'b0});
	assign m_axis_tuser = head.oor;

endmodule

// File: rtl/core/fractional_circular_shift.sv
// Top level of the fractional circular shift with linear interpolation.
//
// Usage: samples are stored and shifted outputs read over one request stream.
// s_axis carries a request: tuser is the mode (0 store a sample, 1 read a
// shifted output); tdata holds index then sample. A store gives no result;
// every read gives one result on m_axis: tdata is the blended value with
// 8 fractional bits, tuser the out-of-range flag. The cfg port writes the
// shift (index 0) and the curve length (index 1); the user writes only while
// the block is idle, as the block itself does not enforce it. Throughput:
// one request per cycle unless busy, a full queue or a full result buffer
// holds s_axis; a read's result passes the queue, memory read and multiply
// into the result buffer. The dual-read sample memory and the single blend
// unit set that figure. A configuration write reduces both offsets modulo
// the length in a bit-serial divider: the input stays unready until done.
// Reset clears the registers (shift 0, full length) and both queues; the
// sample store is not cleared. When m_axis stalls, results gather in a
// four-deep buffer and the request queue fills before s_axis is held.
`timescale 1ns / 1ps

module fractional_circular_shift import fcs_pkg::*; #(
	parameter int MAX_LENGTH = MAX_LENGTH_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_axis_tvalid,
	output logic                  s_axis_tready,
	input  logic [IN_DATA_W-1:0]  s_axis_tdata,  // index, sample, zero pad
	input  logic                  s_axis_tuser,  // mode
	output logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	output logic [OUT_DATA_W-1:0] m_axis_tdata,  // shifted_value
	output logic                  m_axis_tuser,  // out_of_range
	input  logic                  cfg_wen,
	input  logic [REG_IDX_W-1:0]  cfg_index,
	input  logic [SHIFT_W-1:0]    cfg_wdata
);

	logic              busy;
	logic [FRAC_W-1:0] frac;
	offs_t             offs;
	logic              q_push;
	logic              q_pop;
	logic              q_full;
	logic              q_valid;
	req_t              q_in;
	req_t              q_out;
	logic [$clog2(QDEPTH):0] q_count;

	// hold the shift and length; reduce the offsets after each write
	fcs_offset #(
		.MAX_LENGTH (MAX_LENGTH)
	) u_offset (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wen   (cfg_wen),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.frac      (frac),
		.offs      (offs),
		.busy      (busy)
	);

	// classify each request and work out both wrapped addresses
	fcs_front #(
		.MAX_LENGTH (MAX_LENGTH)
	) u_front (
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.offs          (offs),
		.busy          (busy),
		.q_full        (q_full),
		.q_push        (q_push),
		.q_data        (q_in)
	);

	// short queue so that front and back stall independently
	fcs_fifo #(
		.WIDTH ($bits(req_t)),
		.DEPTH (QDEPTH)
	) u_req_q (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_data (q_in),
		.pop       (q_pop),
		.pop_data  (q_out),
		.valid     (q_valid),
		.full      (q_full),
		.count     (q_count)
	);

	// store samples, fetch both taps, blend and buffer the result
	fcs_back #(
		.MAX_LENGTH (MAX_LENGTH)
	) u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.frac          (frac),
		.q_valid       (q_valid && (q_count != '0)),
		.q_data        (q_out),
		.q_pop         (q_pop),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

endmodule

// File: dv/fractional_circular_shift_test.sv
// Self-checking testbench of the fractional circular shift block.
`timescale 1ns / 1ps

module fractional_circular_shift_test;
	import fcs_pkg::*;

	localparam int STORE_DEPTH = MAX_LENGTH_DEF;
	localparam int ONE_Q       = 1 << FRAC_W;
	localparam int STALL_LIMIT = 4000;

	typedef struct {
		logic [OUT_W-1:0] value;
		logic             oor;
	} shift_result_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  s_axis_tvalid = 1'b0;
	logic                  s_axis_tready;
	logic [IN_DATA_W-1:0]  s_axis_tdata = '0;  // index, sample, zero pad
	logic                  s_axis_tuser = 1'b0; // mode
	logic                  m_axis_tvalid;
	logic                  m_axis_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_axis_tdata;        // shifted_value
	logic                  m_axis_tuser;        // out_of_range
	logic                  cfg_wen = 1'b0;
	logic [REG_IDX_W-1:0]  cfg_index = '0;
	logic [SHIFT_W-1:0]    cfg_wdata = '0;

	// own copy of the block state
	logic signed [SAMPLE_W-1:0] curve_copy [STORE_DEPTH];
	bit                         written_mask [STORE_DEPTH];
	logic signed [SHIFT_W-1:0]  shift_reg = '0;
	int                         len_q = STORE_DEPTH;
	int                         floor_q = 0;
	int                         ceil_q = 0;

	shift_result_t pending_outputs [$];
	int            fail_count = 0;
	int            items_sent = 0;
	int            quiet_cycles = 0;
	bit            steady_run = 1'b0;

	fractional_circular_shift dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.cfg_wen       (cfg_wen),
		.cfg_index     (cfg_index),
		.cfg_wdata     (cfg_wdata)
	);

	always #1 clk = ~clk;

	// reduce floor and ceiling of the shift modulo the curve length
	function automatic void reduce_offsets();
		longint s;
		longint fl;
		longint ce;
		s  = shift_reg;
		fl = s >>> FRAC_W;
		ce = fl + ((shift_reg[FRAC_W-1:0] != '0) ? 1 : 0);
		fl = fl % len_q;
		ce = ce % len_q;
		if (fl < 0) fl += len_q;
		if (ce < 0) ce += len_q;
		floor_q = int'(fl);
		ceil_q  = int'(ce);
	endfunction

	function automatic int tap_floor(int idx);
		return (idx + floor_q) % len_q;
	endfunction

	function automatic int tap_ceil(int idx);
		return (idx + ceil_q) % len_q;
	endfunction

	function automatic shift_result_t blend_at(logic [IDX_W-1:0] idx);
		shift_result_t r;
		longint        a;
		longint        b;
		longint        f;
		r.value = '0;
		r.oor   = 1'b1;
		if (int'(idx) >= len_q)
			return r;
		a       = curve_copy[tap_floor(int'(idx))];
		b       = curve_copy[tap_ceil(int'(idx))];
		f       = shift_reg[FRAC_W-1:0];
		r.value = OUT_W'(a * (ONE_Q - f) + b * f);
		r.oor   = 1'b0;
		return r;
	endfunction

	function automatic logic [SAMPLE_W-1:0] pick_sample();
		case ($urandom_range(7))
			0:       return {1'b1, {(SAMPLE_W-1){1'b0}}};
			1:       return {1'b0, {(SAMPLE_W-1){1'b1}}};
			2:       return '0;
			3:       return '1;
			default: return $urandom;
		endcase
	endfunction

	// Offer one request, idling first at random, and update the prediction
	// at the edge where it is taken. Leave tvalid high for the next request.
	task automatic send_req(input logic mode, input logic [IDX_W-1:0] idx,
	                        input logic [SAMPLE_W-1:0] smp);
		if (!steady_run) begin
			while ($urandom_range(99) < 32) begin
				s_axis_tvalid <= 1'b0;
				@(posedge clk);
			end
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser  <= mode;
		s_axis_tdata  <= IN_DATA_W'({smp, idx});
		do @(posedge clk); while (!s_axis_tready);
		items_sent++;
		if (mode == MODE_WRITE) begin
			curve_copy[idx]   = smp;
			written_mask[idx] = 1'b1;
		end else begin
			pending_outputs.push_back(blend_at(idx));
		end
	endtask

	// Read one output position; store any tap that was never written first,
	// so that no in-range read ever uses an undefined entry.
	task automatic read_at(input int idx);
		int taps [2];
		if (idx < len_q) begin
			taps[0] = tap_floor(idx);
			taps[1] = tap_ceil(idx);
			foreach (taps[k])
				if (!written_mask[taps[k]])
					send_req(MODE_WRITE, IDX_W'(taps[k]), pick_sample());
		end
		send_req(MODE_READ, IDX_W'(idx), $urandom);
	endtask

	// Drop valid, let every result drain and the block go quiet.
	task automatic drain_block();
		s_axis_tvalid <= 1'b0;
		while (pending_outputs.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [SHIFT_W-1:0] data);
		int n;
		drain_block();
		cfg_wen   <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= data;
		@(posedge clk);
		cfg_wen <= 1'b0;
		if (idx == REG_SHIFT) begin
			shift_reg = data;
		end else begin
			n = int'(data[LEN_W-1:0]);
			if (n == 0) n = 1;
			if (n > STORE_DEPTH) n = STORE_DEPTH;
			len_q = n;
		end
		reduce_offsets();
	endtask

	// Extreme samples at the ends of the store, read back with no shift.
	task automatic test_store_extremes();
		send_req(MODE_WRITE, 12'd0, {1'b1, {(SAMPLE_W-1){1'b0}}});
		send_req(MODE_WRITE, 12'd1, {1'b0, {(SAMPLE_W-1){1'b1}}});
		send_req(MODE_WRITE, 12'd4095, '1);
		send_req(MODE_WRITE, 12'd2, '0);
		read_at(0);
		read_at(1);
		read_at(4095);
	endtask

	// Largest and smallest shift, a half step, a negative fraction, a whole step.
	task automatic test_shift_extremes();
		write_reg(REG_SHIFT, {1'b0, {(SHIFT_W-1){1'b1}}});
		read_at(1);
		read_at(4095);
		write_reg(REG_SHIFT, {1'b1, {(SHIFT_W-1){1'b0}}});
		read_at(0);
		write_reg(REG_SHIFT, SHIFT_W'(ONE_Q / 2));
		read_at(0);
		write_reg(REG_SHIFT, -SHIFT_W'(3 * ONE_Q / 2));
		read_at(1);
		write_reg(REG_SHIFT, SHIFT_W'(3 * ONE_Q));
		read_at(4094);
	endtask

	// Zero and oversize lengths, a single sample, a length of two, reads past the length.
	task automatic test_length_limits();
		write_reg(REG_LENGTH, '0);
		read_at(0);
		read_at(1);
		read_at(4095);
		write_reg(REG_LENGTH, SHIFT_W'(13'h1FFF));
		read_at(4095);
		write_reg(REG_LENGTH, SHIFT_W'(2));
		read_at(1);
		read_at(2);
	endtask

	// Phases of mixed stores and reads under random shift and length.
	task automatic test_random_traffic();
		int                   target;
		int                   pick;
		logic [LEN_W-1:0]     len_val;
		logic [SHIFT_W-1:0]   shift_val;
		for (int phase = 0; phase < 12; phase++) begin
			case ($urandom_range(4))
				0:       shift_val = {1'b0, {(SHIFT_W-1){1'b1}}};
				1:       shift_val = {1'b1, {(SHIFT_W-1){1'b0}}};
				2:       shift_val = SHIFT_W'($urandom) & ~SHIFT_W'(ONE_Q - 1);
				default: shift_val = SHIFT_W'($urandom);
			endcase
			case ($urandom_range(9))
				0:       len_val = '0;
				1:       len_val = 13'd1;
				2:       len_val = 13'd4096;
				3:       len_val = 13'($urandom_range(8191, 4097));
				4:       len_val = 13'($urandom_range(4095, 65));
				default: len_val = 13'($urandom_range(64, 2));
			endcase
			write_reg(REG_SHIFT, shift_val);
			// upper data bits are outside the length register; vary them
			write_reg(REG_LENGTH, {($urandom_range(1) != 0) ? 8'($urandom) : 8'd0, len_val});
			steady_run = (phase == 4);
			target = items_sent + 160;
			while (items_sent < target) begin
				pick = $urandom_range(99);
				if (pick < 45)
					read_at($urandom_range(len_q - 1));
				else if (pick < 55)
					read_at($urandom_range(STORE_DEPTH - 1));
				else if (pick < 85)
					send_req(MODE_WRITE, IDX_W'($urandom_range(len_q - 1)), pick_sample());
				else
					send_req(MODE_WRITE, IDX_W'($urandom), pick_sample());
			end
			steady_run = 1'b0;
		end
	endtask

	// receiver: stall at random, never in the steady phase
	always @(posedge clk)
		m_axis_tready <= steady_run || ($urandom_range(99) >= 32);

	// compare every result taken with the oldest prediction
	always @(posedge clk) begin : check_results
		shift_result_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (pending_outputs.size() == 0) begin
				$error("unexpected result: shifted_value %0d, out_of_range %0b",
				       $signed(m_axis_tdata[OUT_W-1:0]), m_axis_tuser);
				fail_count++;
			end else begin
				want = pending_outputs.pop_front();
				if (m_axis_tdata[OUT_W-1:0] !== want.value) begin
					$error("shifted_value: expected %0d, got %0d",
					       $signed(want.value), $signed(m_axis_tdata[OUT_W-1:0]));
					fail_count++;
				end
				if (m_axis_tuser !== want.oor) begin
					$error("out_of_range: expected %0b, got %0b", want.oor, m_axis_tuser);
					fail_count++;
				end
			end
		end
	end

	// end the run when nothing moves for too long
	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || cfg_wen)
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	initial begin
		foreach (written_mask[k])
			written_mask[k] = 1'b0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_store_extremes();
		test_shift_extremes();
		test_length_limits();
		test_random_traffic();
		drain_block();
		if (fail_count == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule

// File: fractional_circular_shift.f
rtl/core/fcs_pkg.sv
rtl/core/fcs_fifo.sv
rtl/core/fcs_offset.sv
rtl/core/fcs_front.sv
rtl/core/fcs_back.sv
rtl/core/fractional_circular_shift.sv
dv/fractional_circular_shift_test.sv
